FILE: sv/udpdmx_pkg.sv
// Package with the item types and codes of the UDP port demultiplexer table.
package udpdmx_pkg;

    // Command kinds of an input item.
    localparam logic [2:0] KIND_ALLOCATE = 3'd0;
    localparam logic [2:0] KIND_BIND     = 3'd1;
    localparam logic [2:0] KIND_RELEASE  = 3'd2;
    localparam logic [2:0] KIND_RECEIVE  = 3'd3;
    localparam logic [2:0] KIND_REPORT   = 3'd4;

    // Result status codes.
    localparam logic [3:0] STAT_OK          = 4'd0;
    localparam logic [3:0] STAT_NO_LISTENER = 4'd1;
    localparam logic [3:0] STAT_NO_FREE     = 4'd2;
    localparam logic [3:0] STAT_BAD_HANDLE  = 4'd3;
    localparam logic [3:0] STAT_BAD_PORT    = 4'd4;
    localparam logic [3:0] STAT_SHORT       = 4'd5;
    localparam logic [3:0] STAT_BAD_CS      = 4'd6;
    localparam logic [3:0] STAT_MULTICAST   = 4'd7;
    localparam logic [3:0] STAT_UNREACHABLE = 4'd8;
    localparam logic [3:0] STAT_NO_SOCKET   = 4'd9;

    // Socket entry states.
    localparam logic [1:0] SOCK_FREE   = 2'd0;
    localparam logic [1:0] SOCK_CLOSED = 2'd1;
    localparam logic [1:0] SOCK_OPEN   = 2'd2;

    // UDP header length and the first-octet range of IPv4 multicast.
    localparam logic [15:0] UDP_HEADER_LEN = 16'd8;
    localparam logic [7:0]  MCAST_LOW      = 8'd224;
    localparam logic [7:0]  MCAST_HIGH     = 8'd239;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  socket_index;
        logic [15:0] port;
        logic        has_listener;
        logic        check_cs_option;
        logic [15:0] udp_length;
        logic        checksum_nonzero;
        logic        checksum_good;
        logic [7:0]  dest_first_octet;
        logic        dest_is_broadcast;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  socket_out;
        logic [15:0] payload_length;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [15:0] port;
        logic        check_cs;
    } entry_t;

endpackage

FILE: sv/udp_port_demux_table.sv
// UDP socket table with allocate, bind, release, receive demultiplexing and report lookup.
//
// The block holds SOCKET_COUNT socket entries in a synchronous memory with a
// registered read port; a valid bit per entry makes every entry read as free
// right after reset. One item is worked on at a time. Allocate, an unfiltered
// receive and a report lookup scan the memory one entry per cycle from the
// lowest index and stop at the first hit. Bind reads the entry and writes it
// back. Release and every item decided from its own fields alone need no
// memory read. The result waits in an output register, so the next item can
// be accepted in the cycle after the result is loaded, while it is still
// waiting to be taken. A result that is still untaken in the output register
// delays the next load.
module udp_port_demux_table #(
    parameter int SOCKET_COUNT = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  udpdmx_pkg::in_item_t  s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output udpdmx_pkg::out_item_t m_payload
);

    localparam int IW = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
    localparam logic [IW-1:0] LAST_INDEX = IW'(SOCKET_COUNT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_BIND = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]              state_reg, state_next;
    udpdmx_pkg::in_item_t    item_reg, item_next;
    logic [IW-1:0]           chk_reg, chk_next;
    udpdmx_pkg::out_item_t   res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    udpdmx_pkg::out_item_t   m_payload_reg, m_payload_next;
    logic [SOCKET_COUNT-1:0] valid_reg, valid_next;

    udpdmx_pkg::entry_t      mem [SOCKET_COUNT];
    udpdmx_pkg::entry_t      rd_data_reg;
    logic                    rd_valid_reg;
    logic [IW-1:0]           rd_addr;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    udpdmx_pkg::entry_t      wr_data;

    udpdmx_pkg::entry_t      entry;
    logic                    accept;
    logic                    in_range;
    logic                    out_free;
    logic                    hit;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign in_range  = (32'(s_payload.socket_index) < SOCKET_COUNT);

    // An entry whose valid bit is clear reads as free with port and option zero.
    assign entry = rd_valid_reg ? rd_data_reg : '0;

    // Hit test for the entry under scan, depending on the command kind.
    always_comb begin
        if (item_reg.kind == udpdmx_pkg::KIND_ALLOCATE) begin
            hit = (entry.state == udpdmx_pkg::SOCK_FREE);
        end else begin
            hit = (entry.state == udpdmx_pkg::SOCK_OPEN) && (entry.port == item_reg.port);
        end
    end

    // Socket memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    // Sequencer, memory access and result selection.
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        chk_next       = chk_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        valid_next     = valid_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = chk_reg;
        wr_data        = '0;

        // The output register is emptied when its item is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    item_next = s_payload;
                    chk_next  = '0;
                    res_next  = '0;
                    state_next = S_OUT;
                    case (s_payload.kind)
                        udpdmx_pkg::KIND_ALLOCATE: begin
                            if (!s_payload.has_listener) begin
                                res_next.status = udpdmx_pkg::STAT_NO_LISTENER;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        udpdmx_pkg::KIND_BIND: begin
                            if (!in_range) begin
                                res_next.status = udpdmx_pkg::STAT_BAD_HANDLE;
                            end else if (s_payload.port == 16'd0) begin
                                res_next.status = udpdmx_pkg::STAT_BAD_PORT;
                            end else begin
                                rd_addr    = IW'(s_payload.socket_index);
                                chk_next   = IW'(s_payload.socket_index);
                                state_next = S_BIND;
                            end
                        end
                        udpdmx_pkg::KIND_RELEASE: begin
                            if (!in_range) begin
                                res_next.status = udpdmx_pkg::STAT_BAD_HANDLE;
                            end else begin
                                // Clearing the valid bit returns the entry to free.
                                valid_next[IW'(s_payload.socket_index)] = 1'b0;
                                res_next.status     = udpdmx_pkg::STAT_OK;
                                res_next.socket_out = s_payload.socket_index;
                            end
                        end
                        udpdmx_pkg::KIND_RECEIVE: begin
                            if (s_payload.udp_length < udpdmx_pkg::UDP_HEADER_LEN) begin
                                res_next.status = udpdmx_pkg::STAT_SHORT;
                            end else if (s_payload.dest_first_octet >= udpdmx_pkg::MCAST_LOW &&
                                         s_payload.dest_first_octet <= udpdmx_pkg::MCAST_HIGH)
                            begin
                                res_next.status =
                                    (s_payload.checksum_nonzero && !s_payload.checksum_good) ?
                                    udpdmx_pkg::STAT_BAD_CS : udpdmx_pkg::STAT_MULTICAST;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        udpdmx_pkg::KIND_REPORT: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            res_next.status = udpdmx_pkg::STAT_NO_SOCKET;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Check the entry read last cycle while the next one is read.
                rd_addr = (chk_reg == LAST_INDEX) ? '0 : chk_reg + 1'b1;
                if (hit) begin
                    state_next = S_OUT;
                    res_next.socket_out = 3'(chk_reg);
                    res_next.status     = udpdmx_pkg::STAT_OK;
                    if (item_reg.kind == udpdmx_pkg::KIND_ALLOCATE) begin
                        wr_en            = 1'b1;
                        wr_data.state    = udpdmx_pkg::SOCK_CLOSED;
                        wr_data.port     = 16'd0;
                        wr_data.check_cs = item_reg.check_cs_option;
                        valid_next[chk_reg] = 1'b1;
                    end else if (item_reg.kind == udpdmx_pkg::KIND_RECEIVE) begin
                        if (entry.check_cs && item_reg.checksum_nonzero &&
                            !item_reg.checksum_good) begin
                            res_next.status     = udpdmx_pkg::STAT_BAD_CS;
                            res_next.socket_out = 3'd0;
                        end else begin
                            res_next.payload_length =
                                item_reg.udp_length - udpdmx_pkg::UDP_HEADER_LEN;
                        end
                    end
                end else if (chk_reg == LAST_INDEX) begin
                    state_next = S_OUT;
                    if (item_reg.kind == udpdmx_pkg::KIND_ALLOCATE) begin
                        res_next.status = udpdmx_pkg::STAT_NO_FREE;
                    end else if (item_reg.kind == udpdmx_pkg::KIND_RECEIVE &&
                                 !item_reg.dest_is_broadcast) begin
                        res_next.status = udpdmx_pkg::STAT_UNREACHABLE;
                    end else begin
                        res_next.status = udpdmx_pkg::STAT_NO_SOCKET;
                    end
                end else begin
                    chk_next = chk_reg + 1'b1;
                end
            end

            S_BIND: begin
                // Open the entry on the new port and keep its checksum option.
                wr_en            = 1'b1;
                wr_data.state    = udpdmx_pkg::SOCK_OPEN;
                wr_data.port     = item_reg.port;
                wr_data.check_cs = entry.check_cs;
                valid_next[chk_reg] = 1'b1;
                res_next.status     = udpdmx_pkg::STAT_OK;
                res_next.socket_out = item_reg.socket_index;
                state_next          = S_OUT;
            end

            S_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            valid_reg   <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        chk_reg       <= chk_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
    end

endmodule
